FILE: rtl/core/dll_pkg.sv
package dll_pkg;

  localparam int unsigned CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_REMOVE     = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_e;

  // operation latched for the item in flight
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_UNLINK
  } op_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic fix;
    logic finish;
  } dll_ctrl_t;

  typedef struct packed {
    logic out_free;
  } dll_stat_t;

endpackage

FILE: rtl/core/dll_if.sv
interface dll_req_if #(
  parameter int unsigned ID_W = 4
);
  import dll_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0]  node_id;

  modport source (output valid, output command, output node_id, input ready);
  modport sink   (input valid, input command, input node_id, output ready);
endinterface

interface dll_rsp_if #(
  parameter int unsigned ID_W  = 4,
  parameter int unsigned CNT_W = 5
);
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  node_out;
  logic             node_valid;
  logic             list_empty;
  logic [CNT_W-1:0] count;

  modport source (
    output valid, output node_out, output node_valid, output list_empty, output count,
    input ready
  );
  modport sink (
    input valid, input node_out, input node_valid, input list_empty, input count,
    output ready
  );
endinterface

FILE: rtl/core/dll_ctrl.sv
module dll_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  dll_pkg::dll_stat_t stat_i,
  output dll_pkg::dll_ctrl_t ctrl_o
);
  import dll_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIX
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // the next item may enter during write-back of the current one
  assign req_ready_o = (state_q == ST_IDLE) || ((state_q == ST_FIX) && stat_i.out_free);
  assign accept      = req_valid_i && req_ready_o;

  assign ctrl_o.load   = accept;
  assign ctrl_o.exec   = (state_q == ST_EXEC);
  assign ctrl_o.fix    = (state_q == ST_FIX);
  assign ctrl_o.finish = (state_q == ST_FIX) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_FIX;
      end
      ST_FIX: begin
        if (stat_i.out_free) state_d = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/dll_dpath.sv
module dll_dpath #(
  parameter int unsigned NODE_COUNT = 16,
  parameter int unsigned ID_W       = 4,
  parameter int unsigned PTR_W      = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dll_pkg::dll_ctrl_t        ctrl_i,
  output dll_pkg::dll_stat_t        stat_o,
  input  logic [dll_pkg::CMD_W-1:0] req_command_i,
  input  logic [ID_W-1:0]           req_node_id_i,
  input  logic                      rsp_ready_i,
  output logic                      rsp_valid_o,
  output logic [ID_W-1:0]           node_out_o,
  output logic                      node_valid_o,
  output logic                      list_empty_o,
  output logic [PTR_W-1:0]          count_o
);
  import dll_pkg::*;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

  function automatic logic is_node(input logic [PTR_W-1:0] p);
    is_node = (p < NIL);
  endfunction

  // link memories, null link is NODE_COUNT
  logic [PTR_W-1:0] next_mem [NODE_COUNT];
  logic [PTR_W-1:0] prev_mem [NODE_COUNT];

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [PTR_W-1:0] cnt_q, cnt_d;
  op_e              op_q, op_d;
  logic [ID_W-1:0]  n_q, n_d;
  logic [PTR_W-1:0] next_rd_q, prev_rd_q;
  logic [PTR_W-1:0] fix_next_q, fix_next_d;
  logic [PTR_W-1:0] fix_prev_q, fix_prev_d;

  logic             next_we, prev_we;
  logic [ID_W-1:0]  next_wa, prev_wa;
  logic [PTR_W-1:0] next_wd, prev_wd;
  logic             rd_en;

  logic             rsp_valid_q;
  logic [ID_W-1:0]  node_out_q;
  logic             node_valid_q;
  logic             list_empty_q;
  logic [PTR_W-1:0] count_q;

  cmd_e             cmd;
  logic             id_ok;
  logic [PTR_W-1:0] n_ptr;
  logic [PTR_W-1:0] h_tmp, t_tmp;

  // decode of the incoming transaction
  always_comb begin
    cmd   = cmd_e'(req_command_i);
    id_ok = is_node(PTR_W'(req_node_id_i));
    op_d  = OP_NONE;
    n_d   = req_node_id_i;
    unique case (cmd)
      CMD_PUSH_BACK: begin
        if (id_ok) op_d = OP_PUSH_BACK;
      end
      CMD_PUSH_FRONT: begin
        if (id_ok) op_d = OP_PUSH_FRONT;
      end
      CMD_REMOVE: begin
        if (id_ok && is_node(head_q)) op_d = OP_UNLINK;
      end
      CMD_POP_FRONT: begin
        n_d = head_q[ID_W-1:0];
        if (is_node(head_q)) op_d = OP_UNLINK;
      end
      CMD_POP_BACK: begin
        n_d = tail_q[ID_W-1:0];
        if (is_node(tail_q) && is_node(head_q)) op_d = OP_UNLINK;
      end
      default: begin
        op_d = OP_NONE;
      end
    endcase
  end

  assign rd_en = ctrl_i.load && (op_d != OP_NONE);
  assign n_ptr = PTR_W'(n_q);

  // pointer update and neighbor link writes, then the node's own links
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    fix_next_d = fix_next_q;
    fix_prev_d = fix_prev_q;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_wa    = n_q;
    prev_wa    = n_q;
    next_wd    = NIL;
    prev_wd    = NIL;
    h_tmp      = head_q;
    t_tmp      = tail_q;
    if (ctrl_i.exec) begin
      unique case (op_q)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          if (!is_node(head_q)) begin
            head_d     = n_ptr;
            tail_d     = n_ptr;
            cnt_d      = PTR_W'(1);
            fix_next_d = NIL;
            fix_prev_d = NIL;
          end else if (op_q == OP_PUSH_BACK) begin
            if (is_node(tail_q)) begin
              next_we = 1'b1;
              next_wa = tail_q[ID_W-1:0];
              next_wd = n_ptr;
            end
            fix_next_d = NIL;
            fix_prev_d = tail_q;
            tail_d     = n_ptr;
            if (cnt_q < NIL) cnt_d = cnt_q + PTR_W'(1);
          end else begin
            prev_we    = 1'b1;
            prev_wa    = head_q[ID_W-1:0];
            prev_wd    = n_ptr;
            fix_next_d = head_q;
            fix_prev_d = NIL;
            head_d     = n_ptr;
            if (cnt_q < NIL) cnt_d = cnt_q + PTR_W'(1);
          end
        end
        OP_UNLINK: begin
          if (is_node(next_rd_q)) begin
            prev_we = 1'b1;
            prev_wa = next_rd_q[ID_W-1:0];
            prev_wd = prev_rd_q;
          end
          if (is_node(prev_rd_q)) begin
            next_we = 1'b1;
            next_wa = prev_rd_q[ID_W-1:0];
            next_wd = next_rd_q;
          end
          if (head_q == n_ptr) h_tmp = next_rd_q;
          if (tail_q == n_ptr) t_tmp = prev_rd_q;
          if (!is_node(h_tmp) || !is_node(t_tmp)) begin
            head_d = NIL;
            tail_d = NIL;
          end else begin
            head_d = h_tmp;
            tail_d = t_tmp;
          end
          if (cnt_q != '0) cnt_d = cnt_q - PTR_W'(1);
          fix_next_d = NIL;
          fix_prev_d = NIL;
        end
        default: begin
        end
      endcase
    end else if (ctrl_i.fix && (op_q != OP_NONE)) begin
      // repeats harmlessly while the output is stalled
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wa = n_q;
      prev_wa = n_q;
      next_wd = fix_next_q;
      prev_wd = fix_prev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    // write-first forwarding for a read that overlaps write-back
    if (rd_en) begin
      if (next_we && (next_wa == n_d)) begin
        next_rd_q <= next_wd;
      end else begin
        next_rd_q <= next_mem[n_d];
      end
      if (prev_we && (prev_wa == n_d)) begin
        prev_rd_q <= prev_wd;
      end else begin
        prev_rd_q <= prev_mem[n_d];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) n_q <= n_d;
    fix_next_q <= fix_next_d;
    fix_prev_q <= fix_prev_d;
    if (ctrl_i.finish) begin
      node_out_q   <= (op_q == OP_UNLINK) ? n_q : '0;
      node_valid_q <= (op_q == OP_UNLINK);
      list_empty_q <= !is_node(head_q);
      count_q      <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NIL;
      tail_q      <= NIL;
      cnt_q       <= '0;
      op_q        <= OP_NONE;
      rsp_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      if (ctrl_i.load) op_q <= op_d;
      if (ctrl_i.finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o  = rsp_valid_q;
  assign node_out_o   = node_out_q;
  assign node_valid_o = node_valid_q;
  assign list_empty_o = list_empty_q;
  assign count_o      = count_q;

endmodule

FILE: rtl/core/doubly_linked_list_manager.sv
// a request is loaded, executed and written back, its response registered at write-back once
// the output is free; the next request may enter during write-back: each link memory has one
//   write port and takes a neighbor link write, then the node's own, overlapping the next read
// reset: head and tail null, count zero, output empty; link memories keep no reset value
//   and can be read before written, as by a remove of a node that was never pushed
module doubly_linked_list_manager #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dll_req_if.sink   req_i,
  dll_rsp_if.source rsp_o
);

  localparam int unsigned ID_W  = $clog2(NODE_COUNT);
  localparam int unsigned PTR_W = $clog2(NODE_COUNT + 1);

  dll_pkg::dll_ctrl_t ctrl;
  dll_pkg::dll_stat_t stat;

  dll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dll_dpath #(
    .NODE_COUNT (NODE_COUNT),
    .ID_W       (ID_W),
    .PTR_W      (PTR_W)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .req_command_i (req_i.command),
    .req_node_id_i (req_i.node_id),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .node_out_o    (rsp_o.node_out),
    .node_valid_o  (rsp_o.node_valid),
    .list_empty_o  (rsp_o.list_empty),
    .count_o       (rsp_o.count)
  );

endmodule

FILE: rtl/core/dll_checker.sv
module dll_checker #(
  parameter int unsigned ID_W  = 4,
  parameter int unsigned CNT_W = 5
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [ID_W-1:0]  node_out_i,
  input logic             node_valid_i,
  input logic             list_empty_i,
  input logic [CNT_W-1:0] count_i
);

  // a request transaction is checked to be followed by a valid response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |-> ##3 rsp_valid_i)
    else $error("no response after request transaction");

  // two request transactions never come in back-to-back cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request accepted during execute");

  // nothing taken out reports node zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !node_valid_i) |-> (node_out_i == '0))
    else $error("node_out nonzero without a valid node");

  // a stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(node_out_i) && $stable(node_valid_i) &&
       $stable(list_empty_i) && $stable(count_i)))
    else $error("stalled response changed");

endmodule

bind doubly_linked_list_manager dll_checker #(
  .ID_W  (ID_W),
  .CNT_W (PTR_W)
) u_dll_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .node_out_i   (rsp_o.node_out),
  .node_valid_i (rsp_o.node_valid),
  .list_empty_i (rsp_o.list_empty),
  .count_i      (rsp_o.count)
);

FILE: tb/doubly_linked_list_manager_tb.sv
`timescale 1ns / 100ps

module doubly_linked_list_manager_tb;
  import dll_pkg::*;

  localparam int unsigned NODES = 16;
  localparam int unsigned ID_W = 4;
  localparam int unsigned CNT_W = 5;
  localparam logic [4:0] NIL = 5'd16;
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam int unsigned MAX_CYCLES = 400000;
  localparam int unsigned STALL_CYCLES = 300;

  typedef struct packed {
    logic [ID_W-1:0]  node;
    logic             valid;
    logic             empty;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dll_req_if #(.ID_W(ID_W)) req ();
  dll_rsp_if #(.ID_W(ID_W), .CNT_W(CNT_W)) rsp ();

  doubly_linked_list_manager #(.NODE_COUNT(NODES)) uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .req_i(req),
    .rsp_o(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the list state
  logic [4:0]       head_ptr = NIL;
  logic [4:0]       tail_ptr = NIL;
  logic [CNT_W-1:0] node_total = '0;
  logic [4:0]       next_lnk[NODES];
  logic [4:0]       prev_lnk[NODES];
  logic [NODES-1:0] linked_once = '0;

  list_result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  stall_left = 0;
  bit           quiet = 1'b0;

  function automatic void place_first(logic [3:0] n);
    head_ptr = {1'b0, n};
    tail_ptr = {1'b0, n};
    next_lnk[n] = NIL;
    prev_lnk[n] = NIL;
    node_total = CNT_W'(1);
  endfunction

  function automatic void detach_node(logic [3:0] n);
    logic [4:0] nx;
    logic [4:0] pv;
    nx = next_lnk[n];
    pv = prev_lnk[n];
    if (!nx[4]) prev_lnk[nx[3:0]] = pv;
    if (head_ptr == {1'b0, n}) head_ptr = nx;
    if (!pv[4]) next_lnk[pv[3:0]] = nx;
    if (tail_ptr == {1'b0, n}) tail_ptr = pv;
    next_lnk[n] = NIL;
    prev_lnk[n] = NIL;
    if (node_total != 0) node_total = node_total - 1'b1;
    if (head_ptr[4] || tail_ptr[4]) begin
      head_ptr = NIL;
      tail_ptr = NIL;
    end
  endfunction

  function automatic list_result_t list_step(logic [CMD_W-1:0] cmd, logic [3:0] id);
    list_result_t r;
    logic [3:0]   taken;
    logic         got;
    taken = '0;
    got = 1'b0;
    case (cmd)
      CMD_PUSH_BACK: begin
        linked_once[id] = 1'b1;
        if (head_ptr[4]) begin
          place_first(id);
        end else begin
          if (!tail_ptr[4]) next_lnk[tail_ptr[3:0]] = {1'b0, id};
          prev_lnk[id] = tail_ptr;
          next_lnk[id] = NIL;
          tail_ptr = {1'b0, id};
          if (node_total < NODES) node_total = node_total + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        linked_once[id] = 1'b1;
        if (head_ptr[4]) begin
          place_first(id);
        end else begin
          prev_lnk[head_ptr[3:0]] = {1'b0, id};
          next_lnk[id] = head_ptr;
          prev_lnk[id] = NIL;
          head_ptr = {1'b0, id};
          if (node_total < NODES) node_total = node_total + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!head_ptr[4]) begin
          detach_node(id);
          taken = id;
          got = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (!head_ptr[4]) begin
          taken = head_ptr[3:0];
          detach_node(taken);
          got = 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (!tail_ptr[4] && !head_ptr[4]) begin
          taken = tail_ptr[3:0];
          detach_node(taken);
          got = 1'b1;
        end
      end
      default: ;
    endcase
    r.node = got ? taken : '0;
    r.valid = got;
    r.empty = head_ptr[4];
    r.count = node_total;
    return r;
  endfunction

  // nodes reachable from the head, bounded in case blind pushes made a loop
  function automatic logic [NODES-1:0] members_of_list();
    logic [NODES-1:0] m;
    logic [4:0]       p;
    m = '0;
    p = head_ptr;
    for (int i = 0; i < NODES; i++) begin
      if (p[4]) break;
      m[p[3:0]] = 1'b1;
      p = next_lnk[p[3:0]];
    end
    return m;
  endfunction

  function automatic logic [3:0] pick_node(logic [NODES-1:0] mask);
    logic [3:0] k;
    k = 4'($urandom_range(NODES - 1));
    for (int i = 0; i < NODES; i++) begin
      if (mask[k]) return k;
      k = k + 1'b1;
    end
    return k;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [3:0] id);
    while (!quiet && $urandom_range(99) < 15) @(negedge clk);
    req.valid = 1'b1;
    req.command = cmd;
    req.node_id = id;
    do @(posedge clk); while (req.ready !== 1'b1);
    pending_results.push_back(list_step(cmd, id));
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic drain_list();
    int unsigned guard;
    guard = 0;
    while (!head_ptr[4] && guard < 3 * NODES) begin
      send_item($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK,
                4'($urandom_range(NODES - 1)));
      guard++;
    end
  endtask

  // mostly clean list traffic, a little noise that bends the links
  task automatic random_item(output logic [CMD_W-1:0] cmd, output logic [3:0] id);
    logic [NODES-1:0] members;
    logic [NODES-1:0] stale;
    int unsigned      push_pct;
    int unsigned      filled;
    members = members_of_list();
    stale = linked_once & ~members;
    filled = $countones(members);
    id = 4'($urandom_range(NODES - 1));
    cmd = CMD_POP_FRONT;
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(3))
        0: cmd = CMD_RSVD_FIRST + CMD_W'($urandom_range(2));
        1: begin
          cmd = CMD_REMOVE;
          if (stale != '0) id = pick_node(stale);
          else cmd = CMD_POP_BACK;
        end
        2: begin
          cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
          if (members != '0) id = pick_node(members);
        end
        default: cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      endcase
    end else begin
      push_pct = (filled < 4) ? 70 : (filled > 12) ? 25 : 50;
      if ($urandom_range(99) < push_pct) begin
        if (~members != '0) begin
          id = pick_node(~members);
          cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end
      end else begin
        case ($urandom_range(2))
          0: cmd = CMD_POP_FRONT;
          1: cmd = CMD_POP_BACK;
          default: begin
            if (members != '0) begin
              cmd = CMD_REMOVE;
              id = pick_node(members);
            end
          end
        endcase
      end
    end
  endtask

  task automatic run_random(input int unsigned n);
    logic [CMD_W-1:0] cmd;
    logic [3:0]       id;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 200 == 199) drain_list();
      random_item(cmd, id);
      send_item(cmd, id);
    end
  endtask

  task automatic test_directed();
    send_item(CMD_POP_FRONT, 4'd0);
    send_item(CMD_POP_BACK, 4'd15);
    send_item(CMD_RSVD_FIRST, 4'd5);
    send_item(CMD_RSVD_FIRST + 3'd1, 4'd10);
    send_item(CMD_RSVD_FIRST + 3'd2, 4'd15);
    send_item(CMD_PUSH_BACK, 4'd0);
    send_item(CMD_REMOVE, 4'd0);
    send_item(CMD_REMOVE, 4'd0);
    send_item(CMD_PUSH_FRONT, 4'd15);
    send_item(CMD_POP_FRONT, 4'd7);
    send_item(CMD_PUSH_BACK, 4'd3);
    send_item(CMD_PUSH_BACK, 4'd5);
    send_item(CMD_PUSH_FRONT, 4'd9);
    send_item(CMD_PUSH_FRONT, 4'd10);
    send_item(CMD_REMOVE, 4'd10);
    send_item(CMD_REMOVE, 4'd5);
    send_item(CMD_PUSH_BACK, 4'd7);
    send_item(CMD_REMOVE, 4'd3);
    // node no longer linked, and a push of a node already present
    send_item(CMD_REMOVE, 4'd3);
    send_item(CMD_PUSH_BACK, 4'd9);
    send_item(CMD_POP_BACK, 4'd0);
    send_item(CMD_POP_BACK, 4'd0);
    send_item(CMD_POP_FRONT, 4'd0);
    drain_list();
  endtask

  task automatic test_fill_and_saturate();
    logic [NODES-1:0] members;
    for (int i = 0; i < NODES; i++) begin
      members = members_of_list();
      if (~members == '0) break;
      send_item($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_node(~members));
    end
    send_item(CMD_PUSH_BACK, pick_node(members_of_list()));
    for (int i = 0; i < NODES / 2; i++) begin
      members = members_of_list();
      if (members == '0) break;
      send_item(CMD_REMOVE, pick_node(members));
    end
    drain_list();
  endtask

  task automatic test_backpressure();
    stall_left = STALL_CYCLES;
    run_random(60);
    drain_list();
  endtask

  task automatic test_unthrottled();
    quiet = 1'b1;
    run_random(250);
    drain_list();
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random(1300);
    drain_list();
  endtask

  // receiver side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp.ready = 1'b0;
      stall_left = stall_left - 1;
    end else if (quiet) begin
      rsp.ready = 1'b1;
    end else begin
      rsp.ready = ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin : check_rsp
    list_result_t want;
    if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: node %0d valid %b empty %b count %0d",
                   rsp.node_out, rsp.node_valid, rsp.list_empty, rsp.count);
      end else begin
        want = pending_results.pop_front();
        if (rsp.node_out !== want.node || rsp.node_valid !== want.valid ||
            rsp.list_empty !== want.empty || rsp.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp node %0d %b %b %0d, got node %0d %b %b %0d",
                     want.node, want.valid, want.empty, want.count,
                     rsp.node_out, rsp.node_valid, rsp.list_empty, rsp.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.command = CMD_PUSH_BACK;
    req.node_id = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_fill_and_saturate();
    test_backpressure();
    test_unthrottled();
    test_random_traffic();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: doubly_linked_list_manager.f
rtl/core/dll_pkg.sv
rtl/core/dll_if.sv
rtl/core/dll_ctrl.sv
rtl/core/dll_dpath.sv
rtl/core/doubly_linked_list_manager.sv
rtl/core/dll_checker.sv
tb/doubly_linked_list_manager_tb.sv
